FILE: rtl/vt100_pkg.sv
// ----------------------------------------------------------------------------
// VT100 escape and cursor engine - shared definitions
// Widths, parser modes and character codes used by the engine.
// ----------------------------------------------------------------------------
package vt100_pkg;

    localparam int COORD_BITS = 8;
    localparam int ARG_BITS   = 16;
    localparam int ARG_SLOTS  = 4;
    localparam int SLOT_BITS  = $clog2(ARG_SLOTS);
    // signed width able to hold a coordinate plus or minus a full argument
    localparam int MOVE_BITS  = ((ARG_BITS > COORD_BITS) ? ARG_BITS : COORD_BITS) + 2;

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESC    = 2'd1,
        MODE_CSI    = 2'd2
    } mode_t;

    typedef enum logic {
        REG_SCREEN_COLS = 1'b0,
        REG_SCREEN_ROWS = 1'b1
    } reg_index_t;

    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_SAVE   = 8'h37; // '7'
    localparam logic [7:0] CH_REST   = 8'h38; // '8'
    localparam logic [7:0] CH_LBRACK = 8'h5B; // '['
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_UP     = 8'h41; // 'A'
    localparam logic [7:0] CH_DOWN   = 8'h42; // 'B'
    localparam logic [7:0] CH_FWD    = 8'h43; // 'C'
    localparam logic [7:0] CH_BACK   = 8'h44; // 'D'
    localparam logic [7:0] CH_HOME   = 8'h48; // 'H'
    localparam logic [7:0] CH_HVP    = 8'h66; // 'f'
    localparam logic [7:0] CH_ERASE  = 8'h4A; // 'J'
    localparam logic [7:0] CH_SCP    = 8'h73; // 's'
    localparam logic [7:0] CH_RCP    = 8'h75; // 'u'

    localparam logic [ARG_BITS-1:0] ERASE_ALL = ARG_BITS'(2);

endpackage

FILE: rtl/vt100_escape_cursor_engine.sv
// ----------------------------------------------------------------------------
// VT100 escape and cursor engine
// Tracks cursor, saved cursor and escape parser state for a byte stream and
// reports glyph draws, scrolls, clears and the cursor after each byte.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------------
//  in      | in_valid / in_ready    | byte_in
//  out     | out_valid / out_ready  | print_valid, print_col, print_row,
//          |                        | print_byte, scroll_up, clear_screen,
//          |                        | cursor_col, cursor_row
//  cfg     | APB write/read         | screen_cols @ 0x0, screen_rows @ 0x4
//
//  One byte per cycle unless the output stalls: state is updated and the
//  result registered at the accepting edge; it appears on the next cycle.
//  A new byte is taken while the result register is empty or being drained.
//  A stalled output holds the result and stops further input only then.
//  Reset returns the parser to normal text and homes both cursors.
// ----------------------------------------------------------------------------
module vt100_escape_cursor_engine (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [7:0]                            byte_in,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  print_valid,
    output logic [vt100_pkg::COORD_BITS-1:0]      print_col,
    output logic [vt100_pkg::COORD_BITS-1:0]      print_row,
    output logic [7:0]                            print_byte,
    output logic                                  scroll_up,
    output logic                                  clear_screen,
    output logic [vt100_pkg::COORD_BITS-1:0]      cursor_col,
    output logic [vt100_pkg::COORD_BITS-1:0]      cursor_row,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [vt100_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [vt100_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [vt100_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                  pready
);

    localparam int CB = vt100_pkg::COORD_BITS;
    localparam int AB = vt100_pkg::ARG_BITS;
    localparam int MB = vt100_pkg::MOVE_BITS;
    localparam int SB = vt100_pkg::SLOT_BITS;
    localparam int NS = vt100_pkg::ARG_SLOTS;

    // configuration
    logic [CB-1:0] cols_reg, rows_reg;
    logic          cfg_write;
    vt100_pkg::reg_index_t cfg_sel;

    // parser and cursor state
    vt100_pkg::mode_t mode_reg, mode_next;
    logic [AB-1:0] arg_value_reg [NS];
    logic [AB-1:0] arg_value_next [NS];
    logic          arg_present_reg, arg_present_next;
    logic [SB-1:0] arg_slot_reg, arg_slot_next;
    logic [CB-1:0] cur_col_reg, cur_col_next, cur_row_reg, cur_row_next;
    logic [CB-1:0] saved_col_reg, saved_col_next, saved_row_reg, saved_row_next;

    // result register
    logic          out_valid_reg;
    logic          print_valid_reg, print_valid_next;
    logic [CB-1:0] print_col_reg, print_col_next, print_row_reg, print_row_next;
    logic [7:0]    print_byte_reg, print_byte_next;
    logic          scroll_reg, scroll_next, clear_reg, clear_next;

    logic          accept;
    logic [CB-1:0] cols_dim, rows_dim;
    logic          is_digit, is_semi, abort_args;
    logic [SB:0]   slot_inc;
    logic [AB-1:0] digit_acc;
    logic [AB-1:0] count;
    logic [CB:0]   txt_col, txt_row;

    // clamp a signed target into 0 .. dim-1
    function automatic logic [CB-1:0] clamp(input logic signed [MB-1:0] v,
                                            input logic [CB-1:0] dim);
        logic signed [MB-1:0] lim;
        begin
            lim = $signed({{(MB-CB){1'b0}}, dim}) - MB'(1);
            if (v > lim)
            begin
                clamp = dim - CB'(1);
            end
            else if (v < 0)
            begin
                clamp = '0;
            end
            else
            begin
                clamp = v[CB-1:0];
            end
        end
    endfunction

    function automatic logic signed [MB-1:0] sx_coord(input logic [CB-1:0] v);
        sx_coord = $signed({{(MB-CB){1'b0}}, v});
    endfunction

    function automatic logic signed [MB-1:0] sx_arg(input logic [AB-1:0] v);
        sx_arg = $signed({{(MB-AB){1'b0}}, v});
    endfunction

    assign accept    = in_valid && in_ready;
    assign in_ready  = !out_valid_reg || out_ready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = vt100_pkg::reg_index_t'(paddr[2]);
    assign pready    = 1'b1;

    always_comb
    begin
        unique case (cfg_sel)
            vt100_pkg::REG_SCREEN_COLS: prdata = (vt100_pkg::APB_DATA_BITS)'(cols_reg);
            vt100_pkg::REG_SCREEN_ROWS: prdata = (vt100_pkg::APB_DATA_BITS)'(rows_reg);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= CB'(21);
            rows_reg <= CB'(8);
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                vt100_pkg::REG_SCREEN_COLS: cols_reg <= pwdata[CB-1:0];
                vt100_pkg::REG_SCREEN_ROWS: rows_reg <= pwdata[CB-1:0];
                default: ;
            endcase
        end
    end

    // a zero dimension acts as one
    assign cols_dim = (cols_reg == '0) ? CB'(1) : cols_reg;
    assign rows_dim = (rows_reg == '0) ? CB'(1) : rows_reg;

    assign is_digit  = (byte_in >= vt100_pkg::CH_ZERO) && (byte_in <= vt100_pkg::CH_NINE);
    assign is_semi   = (byte_in == vt100_pkg::CH_SEMI);
    assign slot_inc  = {1'b0, arg_slot_reg} + (SB+1)'(1);
    assign abort_args = (slot_inc == (SB+1)'(NS));
    // value*10 + digit, wrapping at the argument width
    assign digit_acc = (arg_value_reg[arg_slot_reg] << 3) + (arg_value_reg[arg_slot_reg] << 1)
                     + AB'(byte_in - vt100_pkg::CH_ZERO);
    assign count     = arg_present_reg ? arg_value_reg[0] : AB'(1);

    // text path: cursor step, then wrap onto the next row (scroll is decided in the state update)
    always_comb
    begin
        txt_col = {1'b0, cur_col_reg};
        txt_row = {1'b0, cur_row_reg};
        case (byte_in)
            vt100_pkg::CH_BS:
            begin
                if (cur_col_reg != '0)
                begin
                    txt_col = txt_col - (CB+1)'(1);
                end
                else
                begin
                    txt_col = {1'b0, cols_dim} - (CB+1)'(1);
                    if (cur_row_reg != '0)
                    begin
                        txt_row = txt_row - (CB+1)'(1);
                    end
                end
            end
            vt100_pkg::CH_LF:
            begin
                txt_col = '0;
                txt_row = txt_row + (CB+1)'(1);
            end
            vt100_pkg::CH_CR:
            begin
                txt_col = '0;
            end
            default:
            begin
                txt_col = txt_col + (CB+1)'(1);
            end
        endcase
        if (txt_col >= {1'b0, cols_dim})
        begin
            txt_col = '0;
            txt_row = txt_row + (CB+1)'(1);
        end
    end

    // next parser mode
    always_comb
    begin
        mode_next = vt100_pkg::MODE_NORMAL;
        unique case (mode_reg)
            vt100_pkg::MODE_NORMAL:
            begin
                if (byte_in == vt100_pkg::CH_ESC)
                begin
                    mode_next = vt100_pkg::MODE_ESC;
                end
            end
            vt100_pkg::MODE_ESC:
            begin
                if (byte_in == vt100_pkg::CH_LBRACK)
                begin
                    mode_next = vt100_pkg::MODE_CSI;
                end
            end
            vt100_pkg::MODE_CSI:
            begin
                if (is_digit || (is_semi && !abort_args))
                begin
                    mode_next = vt100_pkg::MODE_CSI;
                end
            end
            default: mode_next = vt100_pkg::MODE_NORMAL;
        endcase
    end

    // state updates and result fields
    always_comb
    begin
        for (int i = 0; i < NS; i++)
        begin
            arg_value_next[i] = arg_value_reg[i];
        end
        arg_present_next = arg_present_reg;
        arg_slot_next    = arg_slot_reg;
        cur_col_next     = cur_col_reg;
        cur_row_next     = cur_row_reg;
        saved_col_next   = saved_col_reg;
        saved_row_next   = saved_row_reg;
        print_valid_next = 1'b0;
        print_col_next   = '0;
        print_row_next   = '0;
        print_byte_next  = '0;
        scroll_next      = 1'b0;
        clear_next       = 1'b0;

        unique case (mode_reg)
            vt100_pkg::MODE_NORMAL:
            begin
                if (byte_in != vt100_pkg::CH_ESC)
                begin
                    if ((byte_in != vt100_pkg::CH_BS) && (byte_in != vt100_pkg::CH_LF)
                        && (byte_in != vt100_pkg::CH_CR))
                    begin
                        print_valid_next = 1'b1;
                        print_col_next   = cur_col_reg;
                        print_row_next   = cur_row_reg;
                        print_byte_next  = byte_in;
                    end
                    cur_col_next = txt_col[CB-1:0];
                    if (txt_row >= {1'b0, rows_dim})
                    begin
                        scroll_next  = 1'b1;
                        cur_row_next = rows_dim - CB'(1);
                    end
                    else
                    begin
                        cur_row_next = txt_row[CB-1:0];
                    end
                end
            end
            vt100_pkg::MODE_ESC:
            begin
                case (byte_in)
                    vt100_pkg::CH_SAVE:
                    begin
                        saved_col_next = cur_col_reg;
                        saved_row_next = cur_row_reg;
                    end
                    vt100_pkg::CH_REST:
                    begin
                        cur_col_next = clamp(sx_coord(saved_col_reg), cols_dim);
                        cur_row_next = clamp(sx_coord(saved_row_reg), rows_dim);
                    end
                    default: ;
                endcase
            end
            vt100_pkg::MODE_CSI:
            begin
                if (is_digit || is_semi)
                begin
                    if (!arg_present_reg)
                    begin
                        arg_present_next = 1'b1;
                    end
                    if (is_semi)
                    begin
                        arg_slot_next = slot_inc[SB-1:0];
                    end
                    else
                    begin
                        arg_value_next[arg_slot_reg] = digit_acc;
                    end
                end
                else
                begin
                    case (byte_in)
                        vt100_pkg::CH_HOME, vt100_pkg::CH_HVP:
                        begin
                            if (arg_present_reg)
                            begin
                                cur_col_next = clamp(sx_arg(arg_value_reg[1]) - MB'(1),
                                                     cols_dim);
                                cur_row_next = clamp(sx_arg(arg_value_reg[0]) - MB'(1),
                                                     rows_dim);
                            end
                            else
                            begin
                                cur_col_next = '0;
                                cur_row_next = '0;
                            end
                        end
                        vt100_pkg::CH_UP:
                        begin
                            cur_col_next = clamp(sx_coord(cur_col_reg), cols_dim);
                            cur_row_next = clamp(sx_coord(cur_row_reg) - sx_arg(count),
                                                 rows_dim);
                        end
                        vt100_pkg::CH_DOWN:
                        begin
                            cur_col_next = clamp(sx_coord(cur_col_reg), cols_dim);
                            cur_row_next = clamp(sx_coord(cur_row_reg) + sx_arg(count),
                                                 rows_dim);
                        end
                        vt100_pkg::CH_FWD:
                        begin
                            cur_col_next = clamp(sx_coord(cur_col_reg) + sx_arg(count),
                                                 cols_dim);
                            cur_row_next = clamp(sx_coord(cur_row_reg), rows_dim);
                        end
                        vt100_pkg::CH_BACK:
                        begin
                            cur_col_next = clamp(sx_coord(cur_col_reg) - sx_arg(count),
                                                 cols_dim);
                            cur_row_next = clamp(sx_coord(cur_row_reg), rows_dim);
                        end
                        vt100_pkg::CH_SCP:
                        begin
                            saved_col_next = cur_col_reg;
                            saved_row_next = cur_row_reg;
                        end
                        vt100_pkg::CH_RCP:
                        begin
                            cur_col_next = clamp(sx_coord(saved_col_reg), cols_dim);
                            cur_row_next = clamp(sx_coord(saved_row_reg), rows_dim);
                        end
                        vt100_pkg::CH_ERASE:
                        begin
                            if (arg_present_reg && (arg_value_reg[0] == vt100_pkg::ERASE_ALL))
                            begin
                                clear_next   = 1'b1;
                                cur_col_next = '0;
                                cur_row_next = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase

        // leaving an escape sequence drops all arguments
        if ((mode_reg != vt100_pkg::MODE_NORMAL || byte_in == vt100_pkg::CH_ESC)
            && (mode_next == vt100_pkg::MODE_NORMAL))
        begin
            for (int i = 0; i < NS; i++)
            begin
                arg_value_next[i] = '0;
            end
            arg_present_next = 1'b0;
            arg_slot_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= vt100_pkg::MODE_NORMAL;
            for (int i = 0; i < NS; i++)
            begin
                arg_value_reg[i] <= '0;
            end
            arg_present_reg <= 1'b0;
            arg_slot_reg    <= '0;
            cur_col_reg     <= '0;
            cur_row_reg     <= '0;
            saved_col_reg   <= '0;
            saved_row_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg        <= mode_next;
            for (int i = 0; i < NS; i++)
            begin
                arg_value_reg[i] <= arg_value_next[i];
            end
            arg_present_reg <= arg_present_next;
            arg_slot_reg    <= arg_slot_next;
            cur_col_reg     <= cur_col_next;
            cur_row_reg     <= cur_row_next;
            saved_col_reg   <= saved_col_next;
            saved_row_reg   <= saved_row_next;
        end
    end

    // hold the result until the transaction on the output completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            print_valid_reg <= print_valid_next;
            print_col_reg   <= print_col_next;
            print_row_reg   <= print_row_next;
            print_byte_reg  <= print_byte_next;
            scroll_reg      <= scroll_next;
            clear_reg       <= clear_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign print_valid  = print_valid_reg;
    assign print_col    = print_col_reg;
    assign print_row    = print_row_reg;
    assign print_byte   = print_byte_reg;
    assign scroll_up    = scroll_reg;
    assign clear_screen = clear_reg;
    assign cursor_col   = cur_col_reg;
    assign cursor_row   = cur_row_reg;

endmodule

FILE: dv/vt100_escape_cursor_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VT100 escape and cursor engine - self-checking testbench
// Drives a byte stream through valid/ready and checks every result transaction
// against a fixed row or a cycle-free software copy of the cursor and escape
// parser. It starts with a short directed table, then runs random phases with
// well-formed escape sequences, plain text, control bytes and broken
// sequences. Between phases the screen size is reprogrammed over APB.
// ----------------------------------------------------------------------------
module vt100_escape_cursor_engine_test;

    localparam int RANDOM_PHASES   = 7;
    localparam int BYTES_PER_PHASE = 58;
    localparam int PRINT_CAP       = 40;

    typedef struct packed {
        logic       draw;
        logic [7:0] draw_col;
        logic [7:0] draw_row;
        logic [7:0] glyph;
        logic       scroll;
        logic       clear;
        logic [7:0] col;
        logic [7:0] row;
    } screen_update_t;

    typedef struct {
        logic [7:0]     b;
        bit             fixed;
        screen_update_t want;
    } stim_row_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    logic                                in_ready;
    logic [7:0]                          byte_in = 8'h00;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic                                print_valid;
    logic [vt100_pkg::COORD_BITS-1:0]    print_col;
    logic [vt100_pkg::COORD_BITS-1:0]    print_row;
    logic [7:0]                          print_byte;
    logic                                scroll_up;
    logic                                clear_screen;
    logic [vt100_pkg::COORD_BITS-1:0]    cursor_col;
    logic [vt100_pkg::COORD_BITS-1:0]    cursor_row;
    logic                                psel = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite = 1'b0;
    logic [vt100_pkg::APB_ADDR_BITS-1:0] paddr = '0;
    logic [vt100_pkg::APB_DATA_BITS-1:0] pwdata = '0;
    logic [vt100_pkg::APB_DATA_BITS-1:0] prdata;
    logic                                pready;

    // software copy of the terminal
    logic [7:0]                     scr_cols;
    logic [7:0]                     scr_rows;
    vt100_pkg::mode_t               parse_state;
    logic [vt100_pkg::ARG_BITS-1:0] arg_val [vt100_pkg::ARG_SLOTS];
    bit                             arg_open;
    int                             arg_idx;
    logic [7:0]                     term_col;
    logic [7:0]                     term_row;
    logic [7:0]                     mark_col;
    logic [7:0]                     mark_row;

    screen_update_t screen_updates [$];
    logic [7:0]     byte_burst [$];
    stim_row_t      directed_rows [$];
    int             mismatch_count = 0;
    int             send_idle_pct = 35;
    int             recv_idle_pct = 67;

    int phase_cols [RANDOM_PHASES] = '{0, 255, 1, 255, 80, 7, 21};
    int phase_rows [RANDOM_PHASES] = '{0, 255, 255, 1, 25, 3, 8};

    vt100_escape_cursor_engine uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .byte_in      (byte_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .print_valid  (print_valid),
        .print_col    (print_col),
        .print_row    (print_row),
        .print_byte   (print_byte),
        .scroll_up    (scroll_up),
        .clear_screen (clear_screen),
        .cursor_col   (cursor_col),
        .cursor_row   (cursor_row),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(5_000_000);
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic void home_terminal();
        scr_cols    = 8'd21;
        scr_rows    = 8'd8;
        parse_state = vt100_pkg::MODE_NORMAL;
        foreach (arg_val[i]) arg_val[i] = '0;
        arg_open = 1'b0;
        arg_idx  = 0;
        term_col = '0;
        term_row = '0;
        mark_col = '0;
        mark_row = '0;
    endfunction

    function automatic int dim_of(input logic [7:0] r);
        return (r == 8'd0) ? 1 : int'(r);
    endfunction

    // clamp a sequence-driven move onto the screen
    function automatic void place_cursor(input int c, input int r);
        int cols;
        int rows;
        cols = dim_of(scr_cols);
        rows = dim_of(scr_rows);
        if (c > cols - 1) c = cols - 1;
        if (c < 0) c = 0;
        if (r > rows - 1) r = rows - 1;
        if (r < 0) r = 0;
        term_col = 8'(c);
        term_row = 8'(r);
    endfunction

    function automatic screen_update_t emulate_byte(input logic [7:0] b);
        screen_update_t   u;
        vt100_pkg::mode_t nxt;
        int               cols;
        int               rows;
        int               c;
        int               r;
        int               count;
        u     = '0;
        nxt   = vt100_pkg::MODE_NORMAL;
        cols  = dim_of(scr_cols);
        rows  = dim_of(scr_rows);
        c     = int'(term_col);
        r     = int'(term_row);
        count = arg_open ? int'(arg_val[0]) : 1;
        if (parse_state == vt100_pkg::MODE_NORMAL && b != vt100_pkg::CH_ESC)
        begin
            if (b == vt100_pkg::CH_BS)
            begin
                if (c > 0)
                    c--;
                else
                begin
                    c = cols - 1;
                    if (r > 0) r--;
                end
            end
            else if (b == vt100_pkg::CH_LF)
            begin
                c = 0;
                r++;
            end
            else if (b == vt100_pkg::CH_CR)
                c = 0;
            else
            begin
                u.draw     = 1'b1;
                u.draw_col = term_col;
                u.draw_row = term_row;
                u.glyph    = b;
                c++;
            end
            if (c >= cols)
            begin
                c = 0;
                r++;
            end
            if (r >= rows)
            begin
                u.scroll = 1'b1;
                r = rows - 1;
            end
            term_col = 8'(c);
            term_row = 8'(r);
        end
        else
        begin
            if (parse_state == vt100_pkg::MODE_NORMAL)
                nxt = vt100_pkg::MODE_ESC;
            else if (parse_state == vt100_pkg::MODE_ESC)
            begin
                if (b == vt100_pkg::CH_SAVE)
                begin
                    mark_col = term_col;
                    mark_row = term_row;
                end
                else if (b == vt100_pkg::CH_REST)
                    place_cursor(int'(mark_col), int'(mark_row));
                else if (b == vt100_pkg::CH_LBRACK)
                    nxt = vt100_pkg::MODE_CSI;
            end
            else if (parse_state == vt100_pkg::MODE_CSI)
            begin
                if ((b >= vt100_pkg::CH_ZERO && b <= vt100_pkg::CH_NINE)
                    || b == vt100_pkg::CH_SEMI)
                begin
                    nxt = vt100_pkg::MODE_CSI;
                    if (!arg_open)
                    begin
                        arg_open = 1'b1;
                        arg_idx  = 0;
                    end
                    if (b == vt100_pkg::CH_SEMI)
                    begin
                        arg_idx++;
                        if (arg_idx >= vt100_pkg::ARG_SLOTS) nxt = vt100_pkg::MODE_NORMAL;
                    end
                    else if (arg_idx < vt100_pkg::ARG_SLOTS)
                        arg_val[arg_idx] = vt100_pkg::ARG_BITS'(arg_val[arg_idx] * 10
                                                               + (b - vt100_pkg::CH_ZERO));
                end
                else
                begin
                    case (b)
                        vt100_pkg::CH_HOME, vt100_pkg::CH_HVP:
                            if (arg_open)
                                place_cursor(int'(arg_val[1]) - 1, int'(arg_val[0]) - 1);
                            else
                                place_cursor(0, 0);
                        vt100_pkg::CH_UP:   place_cursor(c, r - count);
                        vt100_pkg::CH_DOWN: place_cursor(c, r + count);
                        vt100_pkg::CH_FWD:  place_cursor(c + count, r);
                        vt100_pkg::CH_BACK: place_cursor(c - count, r);
                        vt100_pkg::CH_SCP:
                        begin
                            mark_col = term_col;
                            mark_row = term_row;
                        end
                        vt100_pkg::CH_RCP:  place_cursor(int'(mark_col), int'(mark_row));
                        vt100_pkg::CH_ERASE:
                            if (arg_open && arg_val[0] == vt100_pkg::ERASE_ALL)
                            begin
                                u.clear = 1'b1;
                                place_cursor(0, 0);
                            end
                        default: ;
                    endcase
                end
            end
            if (nxt == vt100_pkg::MODE_NORMAL)
            begin
                foreach (arg_val[i]) arg_val[i] = '0;
                arg_open = 1'b0;
                arg_idx  = 0;
            end
            parse_state = nxt;
        end
        u.col = term_col;
        u.row = term_row;
        return u;
    endfunction

    function automatic stim_row_t fixed_row(input logic [7:0] b, input logic draw,
                                            input int dc, input int dr, input logic [7:0] g,
                                            input logic scroll, input logic clear,
                                            input int c, input int r);
        stim_row_t row;
        row.b     = b;
        row.fixed = 1'b1;
        row.want  = '{draw, 8'(dc), 8'(dr), g, scroll, clear, 8'(c), 8'(r)};
        return row;
    endfunction

    function automatic stim_row_t pred_row(input logic [7:0] b);
        stim_row_t row;
        row.b     = b;
        row.fixed = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    // hold valid until the transaction is taken, then record what it should produce
    task automatic send_byte(input logic [7:0] b, input bit fixed, input screen_update_t want);
        screen_update_t exp_u;
        int             gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 5) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        byte_in  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        exp_u = emulate_byte(b);
        screen_updates.push_back(fixed ? want : exp_u);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (screen_updates.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic apb_access(input vt100_pkg::reg_index_t idx, input bit wr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_screen(input int cols, input int rows);
        logic [31:0] rd;
        apb_access(vt100_pkg::REG_SCREEN_COLS, 1'b1, 32'(cols), rd);
        scr_cols = 8'(cols);
        apb_access(vt100_pkg::REG_SCREEN_ROWS, 1'b1, 32'(rows), rd);
        scr_rows = 8'(rows);
        apb_access(vt100_pkg::REG_SCREEN_COLS, 1'b0, '0, rd);
        if (rd !== 32'(scr_cols))
            report_mismatch($sformatf("screen_cols read %0h want %0h", rd, scr_cols));
        apb_access(vt100_pkg::REG_SCREEN_ROWS, 1'b0, '0, rd);
        if (rd !== 32'(scr_rows))
            report_mismatch($sformatf("screen_rows read %0h want %0h", rd, scr_rows));
    endtask

    task automatic push_digits(input int ndig);
        for (int k = 0; k < ndig; k++)
            byte_burst.push_back(vt100_pkg::CH_ZERO + 8'($urandom_range(9)));
    endtask

    // one random burst: text, a well-formed sequence, a save/restore or junk
    task automatic build_burst();
        int         kind;
        int         nargs;
        logic [7:0] fin;
        byte_burst.delete();
        kind = $urandom_range(99);
        if (kind < 35)
        begin
            case ($urandom_range(9))
                0:       byte_burst.push_back(vt100_pkg::CH_BS);
                1:       byte_burst.push_back(vt100_pkg::CH_LF);
                2:       byte_burst.push_back(vt100_pkg::CH_CR);
                default: byte_burst.push_back(8'($urandom_range(255)));
            endcase
        end
        else if (kind < 75)
        begin
            case ($urandom_range(8))
                0:       fin = vt100_pkg::CH_UP;
                1:       fin = vt100_pkg::CH_DOWN;
                2:       fin = vt100_pkg::CH_FWD;
                3:       fin = vt100_pkg::CH_BACK;
                4:       fin = vt100_pkg::CH_HOME;
                5:       fin = vt100_pkg::CH_HVP;
                6:       fin = vt100_pkg::CH_SCP;
                7:       fin = vt100_pkg::CH_RCP;
                default: fin = vt100_pkg::CH_ERASE;
            endcase
            byte_burst.push_back(vt100_pkg::CH_ESC);
            byte_burst.push_back(vt100_pkg::CH_LBRACK);
            if (fin == vt100_pkg::CH_ERASE && $urandom_range(3) != 0)
                byte_burst.push_back(vt100_pkg::CH_ZERO + 8'd2);
            else
            begin
                nargs = $urandom_range(vt100_pkg::ARG_SLOTS);
                for (int i = 0; i < nargs; i++)
                begin
                    if (i > 0) byte_burst.push_back(vt100_pkg::CH_SEMI);
                    // mostly short counts, now and then long enough to wrap
                    push_digits(($urandom_range(9) == 0) ? $urandom_range(4, 6)
                                                         : $urandom_range(0, 2));
                end
            end
            byte_burst.push_back(fin);
        end
        else if (kind < 85)
        begin
            byte_burst.push_back(vt100_pkg::CH_ESC);
            byte_burst.push_back($urandom_range(1) ? vt100_pkg::CH_SAVE : vt100_pkg::CH_REST);
        end
        else
        begin
            byte_burst.push_back(vt100_pkg::CH_ESC);
            case ($urandom_range(2))
                0: byte_burst.push_back(8'($urandom_range(255)));
                1:
                begin
                    byte_burst.push_back(vt100_pkg::CH_LBRACK);
                    for (int i = 0; i < vt100_pkg::ARG_SLOTS; i++)
                    begin
                        push_digits($urandom_range(0, 1));
                        byte_burst.push_back(vt100_pkg::CH_SEMI);
                    end
                end
                default:
                begin
                    byte_burst.push_back(vt100_pkg::CH_LBRACK);
                    push_digits(1);
                    byte_burst.push_back(8'($urandom_range(255)));
                end
            endcase
        end
    endtask

    // result side: random back-pressure and field-by-field comparison
    initial
    begin
        screen_update_t got;
        screen_update_t want;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got = '{print_valid, print_col, print_row, print_byte,
                        scroll_up, clear_screen, cursor_col, cursor_row};
                if (screen_updates.size() == 0)
                    report_mismatch("result transaction with nothing pending");
                else
                begin
                    want = screen_updates.pop_front();
                    if (got.draw !== want.draw)
                        report_mismatch($sformatf("print_valid %0h want %0h",
                                                  got.draw, want.draw));
                    if (got.draw_col !== want.draw_col)
                        report_mismatch($sformatf("print_col %0d want %0d",
                                                  got.draw_col, want.draw_col));
                    if (got.draw_row !== want.draw_row)
                        report_mismatch($sformatf("print_row %0d want %0d",
                                                  got.draw_row, want.draw_row));
                    if (got.glyph !== want.glyph)
                        report_mismatch($sformatf("print_byte %0h want %0h",
                                                  got.glyph, want.glyph));
                    if (got.scroll !== want.scroll)
                        report_mismatch($sformatf("scroll_up %0h want %0h",
                                                  got.scroll, want.scroll));
                    if (got.clear !== want.clear)
                        report_mismatch($sformatf("clear_screen %0h want %0h",
                                                  got.clear, want.clear));
                    if (got.col !== want.col)
                        report_mismatch($sformatf("cursor_col %0d want %0d",
                                                  got.col, want.col));
                    if (got.row !== want.row)
                        report_mismatch($sformatf("cursor_row %0d want %0d",
                                                  got.row, want.row));
                end
            end
            out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        int sent;
        home_terminal();
        // screen is 21 x 8 out of reset
        directed_rows = '{
            fixed_row(8'h41, 1'b1, 0, 0, 8'h41, 1'b0, 1'b0, 1, 0),
            fixed_row(vt100_pkg::CH_CR, 1'b0, 0, 0, 8'h00, 1'b0, 1'b0, 0, 0),
            fixed_row(vt100_pkg::CH_BS, 1'b0, 0, 0, 8'h00, 1'b0, 1'b0, 20, 0),
            fixed_row(8'h00, 1'b1, 20, 0, 8'h00, 1'b0, 1'b0, 0, 1),
            fixed_row(vt100_pkg::CH_LF, 1'b0, 0, 0, 8'h00, 1'b0, 1'b0, 0, 2),
            fixed_row(vt100_pkg::CH_ESC, 1'b0, 0, 0, 8'h00, 1'b0, 1'b0, 0, 2),
            pred_row(vt100_pkg::CH_LBRACK),
            pred_row(vt100_pkg::CH_NINE), pred_row(vt100_pkg::CH_NINE),
            pred_row(vt100_pkg::CH_NINE), pred_row(vt100_pkg::CH_NINE),
            pred_row(vt100_pkg::CH_NINE),
            pred_row(vt100_pkg::CH_DOWN),
            pred_row(vt100_pkg::CH_ESC), pred_row(vt100_pkg::CH_LBRACK),
            pred_row(vt100_pkg::CH_UP),
            pred_row(vt100_pkg::CH_ESC), pred_row(vt100_pkg::CH_LBRACK),
            pred_row(vt100_pkg::CH_SEMI), pred_row(vt100_pkg::CH_HVP),
            pred_row(vt100_pkg::CH_ESC), pred_row(vt100_pkg::CH_ESC),
            pred_row(vt100_pkg::CH_LBRACK),
            pred_row(vt100_pkg::CH_ESC), pred_row(vt100_pkg::CH_LBRACK),
            pred_row(vt100_pkg::CH_ZERO + 8'd2),
            fixed_row(vt100_pkg::CH_ERASE, 1'b0, 0, 0, 8'h00, 1'b0, 1'b1, 0, 0),
            pred_row(vt100_pkg::CH_ESC), pred_row(vt100_pkg::CH_LBRACK),
            pred_row(vt100_pkg::CH_SEMI), pred_row(vt100_pkg::CH_SEMI),
            pred_row(vt100_pkg::CH_SEMI), pred_row(vt100_pkg::CH_SEMI),
            fixed_row(8'hFF, 1'b1, 0, 0, 8'hFF, 1'b0, 1'b0, 1, 0)
        };
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].b, directed_rows[i].fixed, directed_rows[i].want);
        drain_results();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p >= 5)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (p >= 3)
            begin
                send_idle_pct = 67;
                recv_idle_pct = 35;
            end
            program_screen(phase_cols[p], phase_rows[p]);
            sent = 0;
            while (sent < BYTES_PER_PHASE)
            begin
                build_burst();
                foreach (byte_burst[i])
                    send_byte(byte_burst[i], 1'b0, '0);
                sent += byte_burst.size();
            end
            drain_results();
        end

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
